// ===== rtl/optimizer_weight_update_top_defines.svh =====
// Assertion macros for the optimizer weight update block.
// Used by optimizer_weight_update_top; needs clk and rst_n in scope.
`ifndef OPTIMIZER_WEIGHT_UPDATE_TOP_DEFINES_SVH
`define OPTIMIZER_WEIGHT_UPDATE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define OWU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("owu: assertion failed");
`define OWU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("owu: assertion failed");
`else
`define OWU_ASSERT_IMP(lbl, ante, cons)
`define OWU_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/owu_pkg.sv =====
// Shared types, codes and sizes for the optimizer weight update block.
// No dependencies.
package owu_pkg;

    localparam logic [1:0] MODE_SGD     = 2'd0;
    localparam logic [1:0] MODE_RMSPROP = 2'd1;
    localparam logic [1:0] MODE_ADAM    = 2'd2;

    localparam logic [2:0] CFG_UPDATE_MODE   = 3'd0;
    localparam logic [2:0] CFG_LEARNING_RATE = 3'd1;
    localparam logic [2:0] CFG_RMS_DECAY     = 3'd2;
    localparam logic [2:0] CFG_MOMENT_DECAY  = 3'd3;
    localparam logic [2:0] CFG_SQUARE_DECAY  = 3'd4;
    localparam logic [2:0] CFG_MOMENT_POWER  = 3'd5;
    localparam logic [2:0] CFG_SQUARE_POWER  = 3'd6;

    localparam logic [1:0]  RST_UPDATE_MODE   = MODE_RMSPROP;
    localparam logic [23:0] RST_LEARNING_RATE = 24'd16777;
    localparam logic [15:0] RST_RMS_DECAY     = 16'd58982;
    localparam logic [15:0] RST_MOMENT_DECAY  = 16'd58982;
    localparam logic [15:0] RST_SQUARE_DECAY  = 16'd64881;

    localparam int ADAM_DW = 33;
    localparam int ADAM_QW = 32;
    localparam int ADAM_AW = ADAM_DW + ADAM_QW;
    localparam int ROOT_XW = 56;
    localparam int ROOT_RW = ROOT_XW / 2;
    localparam int STEP_DW = 29;
    localparam int STEP_QW = 56;
    localparam int STEP_AW = STEP_DW + STEP_QW;

    typedef struct packed {
        logic [1:0]  update_mode;
        logic [23:0] learning_rate;
        logic [15:0] rms_decay;
        logic [15:0] moment_decay;
        logic [15:0] square_decay;
        logic [31:0] moment_decay_power;
        logic [31:0] square_decay_power;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] weight_in;
        logic signed [31:0] gradient_in;
        logic signed [31:0] first_moment_in;
        logic        [31:0] second_moment_in;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] weight_out;
        logic signed [31:0] first_moment_out;
        logic        [31:0] second_moment_out;
        logic               saturated;
    } out_item_t;

    typedef struct packed {
        logic [31:0] w;
        logic [31:0] m_out;
        logic        g_neg;
        logic [31:0] g_mag;
        logic        m_neg;
        logic        ovf_m;
    } m_side_t;

    typedef struct packed {
        logic [31:0] s_out;
        logic        ovf_s;
    } s_side_t;

    typedef struct packed {
        logic [31:0] w;
        logic [31:0] m_out;
        logic [31:0] s_out;
        logic        n_neg;
        logic [55:0] prod;
    } root_side_t;

    typedef struct packed {
        logic [31:0] w;
        logic [31:0] m_out;
        logic [31:0] s_out;
        logic        n_neg;
    } step_side_t;

endpackage

// ===== rtl/optimizer_weight_update_top.sv =====
// Optimizer weight update (SGD / RMSProp / Adam), one parameter per item.
// Throughput one item per cycle while out_ready drains the output register,
// set by the fully pipelined bit-per-stage dividers and root unit.
// A full unread output register stalls the whole pipeline; bubbles are not squeezed.
// Reset: rst_n async active low clears valid bits and loads register defaults.
`include "optimizer_weight_update_top_defines.svh"

module optimizer_weight_update_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  owu_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output owu_pkg::out_item_t out_data,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import owu_pkg::*;

    cfg_t cfg_reg;
    logic adv;
    logic out_vld_reg;
    out_item_t out_data_reg;

    assign adv      = !out_vld_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.update_mode        <= RST_UPDATE_MODE;
            cfg_reg.learning_rate      <= RST_LEARNING_RATE;
            cfg_reg.rms_decay          <= RST_RMS_DECAY;
            cfg_reg.moment_decay       <= RST_MOMENT_DECAY;
            cfg_reg.square_decay       <= RST_SQUARE_DECAY;
            cfg_reg.moment_decay_power <= '0;
            cfg_reg.square_decay_power <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_UPDATE_MODE:   cfg_reg.update_mode        <= cfg_data[1:0];
                CFG_LEARNING_RATE: cfg_reg.learning_rate      <= cfg_data[23:0];
                CFG_RMS_DECAY:     cfg_reg.rms_decay          <= cfg_data[15:0];
                CFG_MOMENT_DECAY:  cfg_reg.moment_decay       <= cfg_data[15:0];
                CFG_SQUARE_DECAY:  cfg_reg.square_decay       <= cfg_data[15:0];
                CFG_MOMENT_POWER:  cfg_reg.moment_decay_power <= cfg_data;
                CFG_SQUARE_POWER:  cfg_reg.square_decay_power <= cfg_data;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // front end
    logic               fr_vld;
    logic [ADAM_AW-1:0] fr_num_m, fr_num_s;
    logic [ADAM_DW-1:0] fr_den_m, fr_den_s;
    m_side_t            fr_side_m;
    s_side_t            fr_side_s;

    owu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .out_valid (fr_vld),
        .num_m     (fr_num_m),
        .num_s     (fr_num_s),
        .den_m     (fr_den_m),
        .den_s     (fr_den_s),
        .side_m    (fr_side_m),
        .side_s    (fr_side_s)
    );

    // bias correction
    logic               dm_vld, ds_vld;
    logic [ADAM_QW-1:0] dm_quo, ds_quo;
    m_side_t            dm_side;
    s_side_t            ds_side;

    owu_div_pipe #(
        .DW (ADAM_DW),
        .QW (ADAM_QW),
        .SW ($bits(m_side_t))
    ) u_div_moment (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fr_vld),
        .num       (fr_num_m),
        .den       (fr_den_m),
        .side_in   (fr_side_m),
        .out_valid (dm_vld),
        .quo       (dm_quo),
        .side_out  (dm_side)
    );

    owu_div_pipe #(
        .DW (ADAM_DW),
        .QW (ADAM_QW),
        .SW ($bits(s_side_t))
    ) u_div_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fr_vld),
        .num       (fr_num_s),
        .den       (fr_den_s),
        .side_in   (fr_side_s),
        .out_valid (ds_vld),
        .quo       (ds_quo),
        .side_out  (ds_side)
    );

    // numerator select and learning-rate product
    logic        adam;
    logic [31:0] vh, n_adam, n_mag, sh_next;
    logic        n_neg;
    logic        mid_vld_reg;
    logic [31:0] mid_sh_reg;
    root_side_t  mid_side_reg;

    assign adam    = (cfg_reg.update_mode == MODE_ADAM);
    assign vh      = (dm_side.ovf_m || dm_quo > 32'h80000000) ? 32'h80000000 : dm_quo;
    assign n_adam  = (!dm_side.m_neg && vh == 32'h80000000) ? 32'h7FFFFFFF : vh;
    assign n_mag   = adam ? n_adam : dm_side.g_mag;
    assign n_neg   = adam ? dm_side.m_neg : dm_side.g_neg;
    assign sh_next = adam ? (ds_side.ovf_s ? 32'hFFFFFFFF : ds_quo) : ds_side.s_out;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mid_sh_reg         <= sh_next;
            mid_side_reg.w     <= dm_side.w;
            mid_side_reg.m_out <= dm_side.m_out;
            mid_side_reg.s_out <= ds_side.s_out;
            mid_side_reg.n_neg <= n_neg;
            mid_side_reg.prod  <= 56'(n_mag) * 56'(cfg_reg.learning_rate);
        end
    end

    // root of the second moment
    logic               sq_vld;
    logic [ROOT_RW-1:0] sq_root;
    root_side_t         sq_side;

    owu_sqrt_pipe #(
        .XW (ROOT_XW),
        .SW ($bits(root_side_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (mid_vld_reg),
        .x         ({mid_sh_reg, 24'b0}),
        .side_in   (mid_side_reg),
        .out_valid (sq_vld),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    // denominator and rounded numerator
    logic [STEP_DW-1:0] den_next;
    logic               form_vld_reg;
    logic [55:0]        form_num_reg;
    logic [STEP_DW-1:0] form_den_reg;
    step_side_t         form_side_reg;

    assign den_next = (cfg_reg.update_mode == MODE_SGD) ? 29'h100_0000
                                                        : ({1'b0, sq_root} + 29'd1);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            form_num_reg        <= sq_side.prod + 56'(den_next[STEP_DW-1:1]);
            form_den_reg        <= den_next;
            form_side_reg.w     <= sq_side.w;
            form_side_reg.m_out <= sq_side.m_out;
            form_side_reg.s_out <= sq_side.s_out;
            form_side_reg.n_neg <= sq_side.n_neg;
        end
    end

    // step division
    logic               st_vld;
    logic [STEP_QW-1:0] st_quo;
    step_side_t         st_side;

    owu_div_pipe #(
        .DW (STEP_DW),
        .QW (STEP_QW),
        .SW ($bits(step_side_t))
    ) u_div_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (form_vld_reg),
        .num       ({29'b0, form_num_reg}),
        .den       (form_den_reg),
        .side_in   (form_side_reg),
        .out_valid (st_vld),
        .quo       (st_quo),
        .side_out  (st_side)
    );

    // weight update and saturation
    logic [57:0] w_ext, q_ext, nw;
    logic        sat;

    assign w_ext = {{26{st_side.w[31]}}, st_side.w};
    assign q_ext = {2'b0, st_quo};
    assign nw    = st_side.n_neg ? (w_ext + q_ext) : (w_ext - q_ext);
    assign sat   = !((&nw[57:31]) || !(|nw[57:31]));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg.weight_out        <= sat ? (nw[57] ? 32'h80000000 : 32'h7FFFFFFF)
                                                  : nw[31:0];
            out_data_reg.first_moment_out  <= st_side.m_out;
            out_data_reg.second_moment_out <= st_side.s_out;
            out_data_reg.saturated         <= sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_vld_reg  <= 1'b0;
            form_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else if (adv)
        begin
            mid_vld_reg  <= dm_vld && ds_vld;
            form_vld_reg <= sq_vld;
            out_vld_reg  <= st_vld;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    `OWU_ASSERT_IMP(a_sat_at_bound, out_valid && out_data.saturated, out_data.weight_out == 32'h7FFFFFFF || out_data.weight_out == 32'h80000000)
    `OWU_ASSERT_IMP(a_den_nonzero, form_vld_reg, form_den_reg != '0)
    `OWU_ASSERT_IMP(a_prod_bound, mid_vld_reg, mid_side_reg.prod <= 56'h7FFFFF80000000)
    `OWU_ASSERT_NXT(a_stall_mid, mid_vld_reg && !in_ready, mid_vld_reg && $stable(mid_side_reg))

endmodule

// ===== rtl/owu_front.sv =====
// Front stages: gradient square, moment blends, bias correction operands.
// Depends on owu_pkg.
module owu_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  owu_pkg::cfg_t     cfg,
    input  logic              in_valid,
    input  owu_pkg::in_item_t in_data,
    output logic              out_valid,
    output logic [owu_pkg::ADAM_AW-1:0] num_m,
    output logic [owu_pkg::ADAM_AW-1:0] num_s,
    output logic [owu_pkg::ADAM_DW-1:0] den_m,
    output logic [owu_pkg::ADAM_DW-1:0] den_s,
    output owu_pkg::m_side_t  side_m,
    output owu_pkg::s_side_t  side_s
);
    import owu_pkg::*;

    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;

    // stage 1
    logic [31:0] g_abs;
    logic [16:0] cm;
    logic [63:0] gsq_full;
    logic signed [48:0] pm_next, pg_next;
    logic [31:0] s1_w_reg, s1_m_reg, s1_s_reg, s1_g_reg;
    logic [62:0] s1_gsq_reg;
    logic signed [48:0] s1_pm_reg, s1_pg_reg;

    assign g_abs    = in_data.gradient_in[31] ? 32'(-in_data.gradient_in)
                                              : in_data.gradient_in;
    assign cm       = 17'h10000 - {1'b0, cfg.moment_decay};
    assign gsq_full = {32'b0, g_abs} * {32'b0, g_abs};
    assign pm_next  = $signed({1'b0, cfg.moment_decay}) * in_data.first_moment_in;
    assign pg_next  = $signed({1'b0, cm}) * in_data.gradient_in;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_w_reg   <= in_data.weight_in;
            s1_m_reg   <= in_data.first_moment_in;
            s1_s_reg   <= in_data.second_moment_in;
            s1_g_reg   <= in_data.gradient_in;
            s1_gsq_reg <= gsq_full[62:0];
            s1_pm_reg  <= pm_next;
            s1_pg_reg  <= pg_next;
        end
    end

    // stage 2
    logic [62:0] gsq_rnd;
    logic signed [49:0] accm;
    logic [49:0] accm_abs;
    logic [50:0] accm_rnd;
    logic [34:0] mr;
    logic [31:0] mb_next;
    logic [31:0] s2_w_reg, s2_m_reg, s2_s_reg, s2_g_reg, s2_mb_reg;
    logic [38:0] s2_g2_reg;

    assign gsq_rnd  = s1_gsq_reg + 63'h80_0000;
    assign accm     = 50'(s1_pm_reg) + 50'(s1_pg_reg);
    assign accm_abs = accm[49] ? 50'(-accm) : accm;
    assign accm_rnd = {1'b0, accm_abs} + 51'd32768;
    assign mr       = accm_rnd[50:16];

    always_comb
    begin
        if (accm[49])
            mb_next = (mr > 35'h080000000) ? 32'h80000000 : 32'(-mr);
        else
            mb_next = (mr > 35'h07FFFFFFF) ? 32'h7FFFFFFF : mr[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_w_reg  <= s1_w_reg;
            s2_m_reg  <= s1_m_reg;
            s2_s_reg  <= s1_s_reg;
            s2_g_reg  <= s1_g_reg;
            s2_g2_reg <= gsq_rnd[62:24];
            s2_mb_reg <= mb_next;
        end
    end

    // stage 3
    logic [15:0] bs;
    logic [16:0] cs;
    logic [31:0] s3_w_reg, s3_m_reg, s3_s_reg, s3_g_reg, s3_mb_reg;
    logic [47:0] s3_ps1_reg;
    logic [55:0] s3_ps2_reg;

    assign bs = (cfg.update_mode == MODE_ADAM) ? cfg.square_decay : cfg.rms_decay;
    assign cs = 17'h10000 - {1'b0, bs};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_w_reg   <= s2_w_reg;
            s3_m_reg   <= s2_m_reg;
            s3_s_reg   <= s2_s_reg;
            s3_g_reg   <= s2_g_reg;
            s3_mb_reg  <= s2_mb_reg;
            s3_ps1_reg <= 48'(bs) * 48'(s2_s_reg);
            s3_ps2_reg <= 56'(cs) * 56'(s2_g2_reg);
        end
    end

    // stage 4
    logic [56:0] accs;
    logic [57:0] accs_rnd;
    logic [41:0] st;
    logic [31:0] s4_w_reg, s4_m_reg, s4_s_reg, s4_g_reg, s4_mb_reg, s4_sb_reg;

    assign accs     = 57'(s3_ps1_reg) + 57'(s3_ps2_reg);
    assign accs_rnd = 58'(accs) + 58'd32768;
    assign st       = accs_rnd[57:16];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_w_reg  <= s3_w_reg;
            s4_m_reg  <= s3_m_reg;
            s4_s_reg  <= s3_s_reg;
            s4_g_reg  <= s3_g_reg;
            s4_mb_reg <= s3_mb_reg;
            s4_sb_reg <= (|st[41:32]) ? 32'hFFFFFFFF : st[31:0];
        end
    end

    // stage 5
    logic [31:0] m_abs, g5_abs;
    logic [32:0] c1, c2;
    logic        ovf_m, ovf_s, adam;
    logic [ADAM_AW-1:0] numm_next, nums_next;
    m_side_t side_m_next;
    s_side_t side_s_next;
    m_side_t side_m_reg;
    s_side_t side_s_reg;
    logic [ADAM_AW-1:0] num_m_reg, num_s_reg;
    logic [ADAM_DW-1:0] den_m_reg, den_s_reg;

    assign adam   = (cfg.update_mode == MODE_ADAM);
    assign m_abs  = s4_mb_reg[31] ? 32'(-s4_mb_reg) : s4_mb_reg;
    assign g5_abs = s4_g_reg[31] ? 32'(-s4_g_reg) : s4_g_reg;
    assign c1     = 33'h1_0000_0000 - {1'b0, cfg.moment_decay_power};
    assign c2     = 33'h1_0000_0000 - {1'b0, cfg.square_decay_power};
    assign ovf_m  = ({1'b0, m_abs} >= c1);
    assign ovf_s  = ({1'b0, s4_sb_reg} >= c2);
    assign numm_next = ovf_m ? '0 : ({1'b0, m_abs, 32'b0} + {33'b0, c1[32:1]});
    assign nums_next = ovf_s ? '0 : ({1'b0, s4_sb_reg, 32'b0} + {33'b0, c2[32:1]});

    always_comb
    begin
        side_m_next.w     = s4_w_reg;
        side_m_next.m_out = adam ? s4_mb_reg : s4_m_reg;
        side_m_next.g_neg = s4_g_reg[31];
        side_m_next.g_mag = g5_abs;
        side_m_next.m_neg = s4_mb_reg[31];
        side_m_next.ovf_m = ovf_m;
        side_s_next.s_out = (cfg.update_mode == MODE_SGD) ? s4_s_reg : s4_sb_reg;
        side_s_next.ovf_s = ovf_s;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_m_reg  <= numm_next;
            num_s_reg  <= nums_next;
            den_m_reg  <= c1;
            den_s_reg  <= c2;
            side_m_reg <= side_m_next;
            side_s_reg <= side_s_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
        end
    end

    assign out_valid = s5_vld_reg;
    assign num_m     = num_m_reg;
    assign num_s     = num_s_reg;
    assign den_m     = den_m_reg;
    assign den_s     = den_s_reg;
    assign side_m    = side_m_reg;
    assign side_s    = side_s_reg;

endmodule

// ===== rtl/owu_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Requires num < den * 2^QW. No package dependency.
module owu_div_pipe #(
    parameter int DW = 33,
    parameter int QW = 32,
    parameter int SW = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [DW+QW-1:0] num,
    input  logic [DW-1:0]    den,
    input  logic [SW-1:0]    side_in,
    output logic             out_valid,
    output logic [QW-1:0]    quo,
    output logic [SW-1:0]    side_out
);
    localparam int AW = DW + QW;

    logic [AW-1:0] acc_reg  [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [SW-1:0] side_reg [QW];
    logic          vld_reg  [QW];

    genvar i;
    generate
        for (i = 0; i < QW; i++)
        begin : g_step
            logic [AW-1:0] acc_prev;
            logic [DW-1:0] den_prev;
            logic [SW-1:0] side_prev;
            logic          vld_prev;
            logic [AW:0]   shl;
            logic [DW:0]   top;
            logic [DW:0]   diff;
            logic          fit;
            logic [AW-1:0] acc_next;

            if (i == 0)
            begin : g_first
                assign acc_prev  = num;
                assign den_prev  = den;
                assign side_prev = side_in;
                assign vld_prev  = in_valid;
            end
            else
            begin : g_rest
                assign acc_prev  = acc_reg[i-1];
                assign den_prev  = den_reg[i-1];
                assign side_prev = side_reg[i-1];
                assign vld_prev  = vld_reg[i-1];
            end

            assign shl      = {acc_prev, 1'b0};
            assign top      = shl[AW:QW];
            assign fit      = (top >= {1'b0, den_prev});
            assign diff     = top - {1'b0, den_prev};
            assign acc_next = fit ? {diff[DW-1:0], shl[QW-1:1], 1'b1}
                                  : {top[DW-1:0], shl[QW-1:1], 1'b0};

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    acc_reg[i]  <= acc_next;
                    den_reg[i]  <= den_prev;
                    side_reg[i] <= side_prev;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[i] <= 1'b0;
                else if (adv)
                    vld_reg[i] <= vld_prev;
            end
        end
    endgenerate

    assign out_valid = vld_reg[QW-1];
    assign quo       = acc_reg[QW-1][QW-1:0];
    assign side_out  = side_reg[QW-1];

endmodule

// ===== rtl/owu_sqrt_pipe.sv =====
// Pipelined integer square root, one root bit per stage (floor).
// No package dependency.
module owu_sqrt_pipe #(
    parameter int XW = 56,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  logic [XW-1:0]   x,
    input  logic [SW-1:0]   side_in,
    output logic            out_valid,
    output logic [XW/2-1:0] root,
    output logic [SW-1:0]   side_out
);
    localparam int RW = XW / 2;

    logic [RW+1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];
    logic [XW-1:0] xs_reg   [RW];
    logic [SW-1:0] side_reg [RW];
    logic          vld_reg  [RW];

    genvar i;
    generate
        for (i = 0; i < RW; i++)
        begin : g_step
            logic [RW+1:0] rem_prev;
            logic [RW-1:0] root_prev;
            logic [XW-1:0] xs_prev;
            logic [SW-1:0] side_prev;
            logic          vld_prev;
            logic [RW+1:0] r4;
            logic [RW+1:0] trial;
            logic          fit;

            if (i == 0)
            begin : g_first
                assign rem_prev  = '0;
                assign root_prev = '0;
                assign xs_prev   = x;
                assign side_prev = side_in;
                assign vld_prev  = in_valid;
            end
            else
            begin : g_rest
                assign rem_prev  = rem_reg[i-1];
                assign root_prev = root_reg[i-1];
                assign xs_prev   = xs_reg[i-1];
                assign side_prev = side_reg[i-1];
                assign vld_prev  = vld_reg[i-1];
            end

            assign r4    = {rem_prev[RW-1:0], xs_prev[XW-1:XW-2]};
            assign trial = {1'b0, root_prev[RW-2:0], 2'b01};
            assign fit   = (r4 >= trial);

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[i]  <= fit ? (r4 - trial) : r4;
                    root_reg[i] <= {root_prev[RW-2:0], fit};
                    xs_reg[i]   <= {xs_prev[XW-3:0], 2'b00};
                    side_reg[i] <= side_prev;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[i] <= 1'b0;
                else if (adv)
                    vld_reg[i] <= vld_prev;
            end
        end
    endgenerate

    assign out_valid = vld_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign side_out  = side_reg[RW-1];

endmodule
